@@ sv/tnia_pkg.sv @@
// ----------------------------------------------------------------------------
// tnia_pkg
// Shared sizes, codes and controller/datapath interface types for the
// trace noise interval accumulator.
// ----------------------------------------------------------------------------
package tnia_pkg;

  localparam int TRACE_DEPTH = 1024;
  localparam int MAX_CORES   = 8;
  localparam int MAX_NODES   = 16;

  localparam int IDX_W  = $clog2(TRACE_DEPTH);
  localparam int CORE_W = $clog2(MAX_CORES);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ADDR_W = CORE_W + IDX_W;
  localparam int PTR_W  = IDX_W + 1;
  localparam int TL_W   = 11;
  localparam int CPN_W  = 4;
  localparam int TGT_W  = 7;
  localparam int ENT_W  = 10;
  localparam int DW     = 64;
  localparam int CNT_W  = 7;
  localparam int IN_W   = 344;

  localparam logic [1:0] OP_EVENT  = 2'd0;
  localparam logic [1:0] OP_OFFSET = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic CFG_TRACE_LENGTH   = 1'b0;
  localparam logic CFG_CORES_PER_NODE = 1'b1;

  localparam logic [1:0] RD_LAST = 2'd0;
  localparam logic [1:0] RD_MID  = 2'd1;
  localparam logic [1:0] RD_LEAD = 2'd2;
  localparam logic [1:0] RD_WALK = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       wr_event;
    logic       wr_offset;
    logic       div_id;
    logic       div_mod;
    logic       div_step;
    logic       id_done;
    logic       start_set;
    logic       bs_eval;
    logic       walk_init;
    logic       lead_eval;
    logic       walk_eval;
    logic       res_ok;
    logic       res_err;
    logic [1:0] rd_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_done;
    logic       span_err;
    logic       bs_more;
    logic       lead_any;
    logic       walk_more;
    logic       walk_hit;
    logic       out_free;
  } stat_t;

endpackage

@@ sv/tnia_ctrl.sv @@
// ----------------------------------------------------------------------------
// tnia_ctrl
// Sequencer for loads and queries: divider runs, binary search, overlap
// walk and result hand-off.
// ----------------------------------------------------------------------------
module tnia_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tnia_pkg::stat_t stat,
  output tnia_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_DIV_ID  = 4'd2;
  localparam logic [3:0] S_RD_LAST = 4'd3;
  localparam logic [3:0] S_SPAN    = 4'd4;
  localparam logic [3:0] S_DIV_MOD = 4'd5;
  localparam logic [3:0] S_BS_CHK  = 4'd6;
  localparam logic [3:0] S_BS_RD   = 4'd7;
  localparam logic [3:0] S_BS_EV   = 4'd8;
  localparam logic [3:0] S_LEAD_RD = 4'd9;
  localparam logic [3:0] S_LEAD_EV = 4'd10;
  localparam logic [3:0] S_WALK_CHK = 4'd11;
  localparam logic [3:0] S_WALK_RD = 4'd12;
  localparam logic [3:0] S_WALK_EV = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;
  localparam logic [3:0] S_ERR     = 4'd15;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = tnia_pkg::RD_LAST;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.op)
          tnia_pkg::OP_EVENT:  cmd.wr_event = 1'b1;
          tnia_pkg::OP_OFFSET: cmd.wr_offset = 1'b1;
          tnia_pkg::OP_QUERY: begin
            cmd.div_id = 1'b1;
            state_next = S_DIV_ID;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV_ID: begin
        if (stat.div_done) begin
          cmd.id_done = 1'b1;
          state_next  = S_RD_LAST;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RD_LAST: begin
        cmd.rd_sel = tnia_pkg::RD_LAST;
        state_next = S_SPAN;
      end
      S_SPAN: begin
        if (stat.span_err) begin
          state_next = S_ERR;
        end else begin
          cmd.div_mod = 1'b1;
          state_next  = S_DIV_MOD;
        end
      end
      S_DIV_MOD: begin
        if (stat.div_done) begin
          cmd.start_set = 1'b1;
          state_next    = S_BS_CHK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_BS_CHK: begin
        if (stat.bs_more) begin
          state_next = S_BS_RD;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = stat.lead_any ? S_LEAD_RD : S_WALK_CHK;
        end
      end
      S_BS_RD: begin
        cmd.rd_sel = tnia_pkg::RD_MID;
        state_next = S_BS_EV;
      end
      S_BS_EV: begin
        cmd.bs_eval = 1'b1;
        state_next  = S_BS_CHK;
      end
      S_LEAD_RD: begin
        cmd.rd_sel = tnia_pkg::RD_LEAD;
        state_next = S_LEAD_EV;
      end
      S_LEAD_EV: begin
        cmd.lead_eval = 1'b1;
        state_next    = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        state_next = stat.walk_more ? S_WALK_RD : S_DONE;
      end
      S_WALK_RD: begin
        cmd.rd_sel = tnia_pkg::RD_WALK;
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (stat.walk_hit) begin
          cmd.walk_eval = 1'b1;
          state_next    = S_WALK_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_ok = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.res_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/tnia_dp.sv @@
// ----------------------------------------------------------------------------
// tnia_dp
// Datapath: configuration registers, trace and offset memories, shared
// restoring divider, search pointers, accumulator and output register.
// ----------------------------------------------------------------------------
module tnia_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [tnia_pkg::TL_W-1:0]   cfg_data,
  input  logic [tnia_pkg::IN_W-1:0]   s_tdata,
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tnia_pkg::DW-1:0]     m_tdata,
  output logic [0:0]                  m_tuser,
  input  tnia_pkg::cmd_t              cmd,
  output tnia_pkg::stat_t             stat
);

  localparam int DW    = tnia_pkg::DW;
  localparam int IDX_W = tnia_pkg::IDX_W;
  localparam int PTR_W = tnia_pkg::PTR_W;

  logic [tnia_pkg::TL_W-1:0]  trace_length;
  logic [tnia_pkg::CPN_W-1:0] cores_per_node;

  logic [1:0]                 op;
  logic [tnia_pkg::TGT_W-1:0] target;
  logic [tnia_pkg::ENT_W-1:0] entry;
  logic [DW-1:0] ev_time, ev_len, off_in, ws, we;

  logic [DW-1:0] times   [tnia_pkg::MAX_CORES*tnia_pkg::TRACE_DEPTH];
  logic [DW-1:0] lengths [tnia_pkg::MAX_CORES*tnia_pkg::TRACE_DEPTH];
  logic [DW-1:0] offsets [tnia_pkg::MAX_NODES];
  logic [DW-1:0] t_q, d_q, off_q;

  logic [tnia_pkg::CORE_W-1:0] core;
  logic [tnia_pkg::NODE_W-1:0] node;

  logic [DW-1:0] rem, dvd, dvs;
  logic [tnia_pkg::CNT_W-1:0] cnt;
  logic [DW+1:0] trial;

  logic [DW-1:0] span, start, endv, total;
  logic [PTR_W-1:0] lo, hi, nxt, n_eff;
  logic [PTR_W:0]   mid_sum;
  logic [IDX_W-1:0] mid, rd_idx;
  logic [tnia_pkg::CPN_W-1:0] cpn_eff;
  logic [DW-1:0] gap;
  logic [DW:0]   acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_length   <= tnia_pkg::TL_W'(1);
      cores_per_node <= tnia_pkg::CPN_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tnia_pkg::CFG_TRACE_LENGTH:   trace_length <= cfg_data;
        tnia_pkg::CFG_CORES_PER_NODE: cores_per_node <= cfg_data[tnia_pkg::CPN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (trace_length == '0) begin
      n_eff = PTR_W'(1);
    end else if (trace_length > tnia_pkg::TL_W'(tnia_pkg::TRACE_DEPTH)) begin
      n_eff = PTR_W'(tnia_pkg::TRACE_DEPTH);
    end else begin
      n_eff = PTR_W'(trace_length);
    end
    if (cores_per_node == '0) begin
      cpn_eff = tnia_pkg::CPN_W'(1);
    end else if (cores_per_node > tnia_pkg::CPN_W'(tnia_pkg::MAX_CORES)) begin
      cpn_eff = tnia_pkg::CPN_W'(tnia_pkg::MAX_CORES);
    end else begin
      cpn_eff = cores_per_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op      <= s_tuser;
      target  <= s_tdata[6:0];
      entry   <= s_tdata[16:7];
      ev_time <= s_tdata[80:17];
      ev_len  <= s_tdata[144:81];
      off_in  <= s_tdata[208:145];
      ws      <= s_tdata[272:209];
      we      <= s_tdata[336:273];
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    case (cmd.rd_sel)
      tnia_pkg::RD_LAST: rd_idx = IDX_W'(n_eff - PTR_W'(1));
      tnia_pkg::RD_MID:  rd_idx = mid;
      tnia_pkg::RD_LEAD: rd_idx = IDX_W'(lo - PTR_W'(1));
      default:           rd_idx = nxt[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_event && target < tnia_pkg::TGT_W'(tnia_pkg::MAX_CORES)
        && {1'b0, entry} < (tnia_pkg::ENT_W+1)'(tnia_pkg::TRACE_DEPTH)) begin
      times[{target[tnia_pkg::CORE_W-1:0], entry[IDX_W-1:0]}]   <= ev_time;
      lengths[{target[tnia_pkg::CORE_W-1:0], entry[IDX_W-1:0]}] <= ev_len;
    end
    t_q <= times[{core, rd_idx}];
    d_q <= lengths[{core, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_offset && target < tnia_pkg::TGT_W'(tnia_pkg::MAX_NODES)) begin
      offsets[target[tnia_pkg::NODE_W-1:0]] <= off_in;
    end
    off_q <= offsets[node];
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {1'b0, rem, dvd[DW-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_id) begin
      rem <= '0;
      dvd <= {target, (DW-tnia_pkg::TGT_W)'(0)};
      dvs <= DW'(cpn_eff);
      cnt <= tnia_pkg::CNT_W'(tnia_pkg::TGT_W);
    end else if (cmd.div_mod) begin
      rem <= '0;
      dvd <= ws + off_q;
      dvs <= t_q - span;
      cnt <= tnia_pkg::CNT_W'(DW);
    end else if (cmd.div_step) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW-1:0];
        dvd <= {dvd[DW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-2:0], dvd[DW-1]};
        dvd <= {dvd[DW-2:0], 1'b0};
      end
      cnt <= cnt - tnia_pkg::CNT_W'(1);
    end
  end

  assign gap = start - t_q;
  assign acc = {1'b0, total} + {1'b0, d_q};

  always_ff @(posedge clk) begin
    if (cmd.id_done) begin
      core <= rem[tnia_pkg::CORE_W-1:0];
      node <= dvd[tnia_pkg::NODE_W-1:0];
      span <= we - ws;
    end
    if (cmd.start_set) begin
      start <= rem;
      endv  <= rem + span;
      lo    <= '0;
      hi    <= n_eff - PTR_W'(1);
    end
    if (cmd.bs_eval) begin
      if (t_q > start) begin
        hi <= PTR_W'(mid);
      end else begin
        lo <= PTR_W'(mid) + PTR_W'(1);
      end
    end
    if (cmd.walk_init) begin
      nxt   <= lo;
      total <= '0;
    end
    if (cmd.lead_eval) begin
      total <= (d_q > gap) ? d_q - gap : '0;
    end
    if (cmd.walk_eval) begin
      total <= acc[DW] ? '1 : acc[DW-1:0];
      nxt   <= nxt + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_ok || cmd.res_err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ok) begin
      m_tdata <= total;
      m_tuser <= 1'b0;
    end else if (cmd.res_err) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end
  end

  always_comb begin
    stat.op        = op;
    stat.div_done  = (cnt == '0);
    stat.span_err  = (span >= t_q);
    stat.bs_more   = (lo < hi);
    stat.lead_any  = (lo != '0);
    stat.walk_more = (nxt < n_eff);
    stat.walk_hit  = (endv > t_q);
    stat.out_free  = !m_tvalid || m_tready;
  end

endmodule

@@ sv/trace_noise_interval_accumulator.sv @@
// ----------------------------------------------------------------------------
// trace_noise_interval_accumulator
// Per-core noise trace store with node start offsets; answers interval
// noise queries.
// ----------------------------------------------------------------------------
// Loads (event or node offset) pass through a decode state. A query makes
// a 7-step and a 64-step run of the bit-serial divider, a binary search and
// a walk over the events the interval end passes; each search probe and walk
// step has a check, a read and an evaluate state for the registered trace
// memory read. Results wait in an output register; a query that finishes
// while the previous result is still held stalls until it leaves.
// ----------------------------------------------------------------------------
module trace_noise_interval_accumulator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [tnia_pkg::TL_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // target_id, entry_index, event_time, event_length, node_offset,
  // window_start, window_end
  input  logic [tnia_pkg::IN_W-1:0] s_tdata,
  // operation
  input  logic [1:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // noise_total
  output logic [tnia_pkg::DW-1:0]   m_tdata,
  // range_error
  output logic [0:0]                m_tuser
);

  tnia_pkg::cmd_t  cmd;
  tnia_pkg::stat_t stat;

  tnia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tnia_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
